// ===== design/interval_arithmetic_unit_core_defines.svh =====
// Assertion helpers shared by the interval unit RTL.
`ifndef INTERVAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define INTERVAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iau check failed");

// next-cycle implication
`define IAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iau check failed");

`endif

// ===== design/iau_pkg.sv =====
package iau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int QW        = 2 * FRAC_BITS + 1;
	localparam int NCELL     = QW;

	localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_NEG   = 3'd3,
		CMD_RECIP = 3'd4,
		CMD_DIV   = 3'd5
	} iau_cmd_t;

	// one lane of the restoring divider chain
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] quot;
		logic [QW-1:0] dvd;
		logic [DW-1:0] dvs;
		logic          neg;
		logic          zero;
	} div_lane_t;

	typedef struct packed {
		logic signed [DW-1:0] val;
		logic                 ov;
		logic                 dz;
	} recip_t;

	typedef struct packed {
		logic signed [DW-1:0] val;
		logic                 ov;
	} sat_t;

	function automatic sat_t sat64(input logic signed [63:0] v);
		sat_t r;
		r.ov  = 1'b0;
		r.val = v[DW-1:0];
		if (v > 64'(Q_MAX)) begin
			r.ov  = 1'b1;
			r.val = Q_MAX;
		end else if (v < 64'(Q_MIN)) begin
			r.ov  = 1'b1;
			r.val = Q_MIN;
		end
		return r;
	endfunction

	// quotient magnitude -> signed, saturated reciprocal
	function automatic recip_t recip_fin(input div_lane_t l);
		recip_t     r;
		logic [63:0] q;
		logic [63:0] nq;
		q   = 64'(l.quot);
		nq  = ~q + 64'd1;
		r.dz  = 1'b0;
		r.ov  = 1'b0;
		r.val = q[DW-1:0];
		if (l.zero) begin
			r.dz  = 1'b1;
			r.ov  = 1'b1;
			r.val = Q_MAX;
		end else if (!l.neg) begin
			if (q > 64'(unsigned'(Q_MAX))) begin
				r.ov  = 1'b1;
				r.val = Q_MAX;
			end
		end else begin
			if (q > 64'(unsigned'(Q_MIN))) begin
				r.ov  = 1'b1;
				r.val = Q_MIN;
			end else begin
				r.val = nq[DW-1:0];
			end
		end
		return r;
	endfunction

endpackage

// ===== design/iau_div_cell.sv =====
module iau_div_cell (
	input  logic              clk,
	input  logic              en,
	input  iau_pkg::div_lane_t lane_in,
	output iau_pkg::div_lane_t lane_out
);
	import iau_pkg::*;

	logic [DW:0] trial;
	logic        ge;
	logic [DW:0] diff;
	div_lane_t   nxt;

	always_comb begin
		trial = {lane_in.rem, lane_in.dvd[QW-1]};
		ge    = trial >= {1'b0, lane_in.dvs};
		diff  = trial - {1'b0, lane_in.dvs};
		nxt       = lane_in;
		nxt.rem   = ge ? diff[DW-1:0] : trial[DW-1:0];
		nxt.quot  = {lane_in.quot[QW-2:0], ge};
		nxt.dvd   = {lane_in.dvd[QW-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out <= nxt;
		end
	end

endmodule

// ===== design/interval_arithmetic_unit_core.sv =====
// Interval unit: accepts one beat per cycle unless stalled and returns one result beat
// per item, in order, on Q16.16 operands. The path runs through the reciprocal divider,
// a chain of 2*FRAC_BITS+1 cells that each resolve one quotient bit, followed by a register
// for reciprocal fixup, one for the four endpoint products and the output register.
// All opcodes take the same path. A stall on the output holds the whole pipe.
`include "interval_arithmetic_unit_core_defines.svh"

module interval_arithmetic_unit_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        cmd,
	input  logic signed [iau_pkg::DW-1:0]     a_low,
	input  logic signed [iau_pkg::DW-1:0]     a_high,
	input  logic signed [iau_pkg::DW-1:0]     b_low,
	input  logic signed [iau_pkg::DW-1:0]     b_high,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [iau_pkg::DW-1:0]     res_low,
	output logic signed [iau_pkg::DW-1:0]     res_high,
	output logic                              overflow,
	output logic                              div_zero
);
	import iau_pkg::*;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	div_lane_t            lo_c [0:NCELL];
	div_lane_t            hi_c [0:NCELL];
	logic [2:0]           cmd_p [0:NCELL];
	logic signed [DW-1:0] al_p [0:NCELL];
	logic signed [DW-1:0] ah_p [0:NCELL];
	logic signed [DW-1:0] bl_p [0:NCELL];
	logic signed [DW-1:0] bh_p [0:NCELL];
	logic                 vld_p [0:NCELL];

	logic signed [DW-1:0] xl, xh;

	always_comb begin
		xl = (cmd == CMD_RECIP) ? a_low  : b_low;
		xh = (cmd == CMD_RECIP) ? a_high : b_high;
		lo_c[0].rem  = '0;
		lo_c[0].quot = '0;
		lo_c[0].dvd  = {1'b1, {(QW-1){1'b0}}};
		lo_c[0].dvs  = xl[DW-1] ? (~xl + 1'b1) : xl;
		lo_c[0].neg  = xl[DW-1];
		lo_c[0].zero = (xl == '0);
		hi_c[0].rem  = '0;
		hi_c[0].quot = '0;
		hi_c[0].dvd  = {1'b1, {(QW-1){1'b0}}};
		hi_c[0].dvs  = xh[DW-1] ? (~xh + 1'b1) : xh;
		hi_c[0].neg  = xh[DW-1];
		hi_c[0].zero = (xh == '0);
	end

	assign cmd_p[0] = cmd;
	assign al_p[0]  = a_low;
	assign ah_p[0]  = a_high;
	assign bl_p[0]  = b_low;
	assign bh_p[0]  = b_high;
	assign vld_p[0] = in_valid;

	for (genvar i = 0; i < NCELL; i++) begin : g_chain
		iau_div_cell u_lo (.clk(clk), .en(adv), .lane_in(lo_c[i]), .lane_out(lo_c[i+1]));
		iau_div_cell u_hi (.clk(clk), .en(adv), .lane_in(hi_c[i]), .lane_out(hi_c[i+1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[i+1] <= 1'b0;
			end else if (adv) begin
				vld_p[i+1] <= vld_p[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cmd_p[i+1] <= cmd_p[i];
				al_p[i+1]  <= al_p[i];
				ah_p[i+1]  <= ah_p[i];
				bl_p[i+1]  <= bl_p[i];
				bh_p[i+1]  <= bh_p[i];
			end
		end
	end

	// reciprocal fixup and ordering
	recip_t r1, r2;
	logic signed [DW-1:0] rl, rh;
	always_comb begin
		r1 = recip_fin(lo_c[NCELL]);
		r2 = recip_fin(hi_c[NCELL]);
		rl = (r1.val <= r2.val) ? r1.val : r2.val;
		rh = (r1.val <= r2.val) ? r2.val : r1.val;
	end

	logic                 vld_s1;
	logic [2:0]           cmd_s1;
	logic signed [DW-1:0] al_s1, ah_s1, bl_s1, bh_s1, rl_s1, rh_s1;
	logic                 rov_s1, rdz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_p[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_p[NCELL];
			al_s1  <= al_p[NCELL];
			ah_s1  <= ah_p[NCELL];
			bl_s1  <= bl_p[NCELL];
			bh_s1  <= bh_p[NCELL];
			rl_s1  <= rl;
			rh_s1  <= rh;
			rov_s1 <= r1.ov | r2.ov;
			rdz_s1 <= r1.dz | r2.dz;
		end
	end

	// products and linear ops
	logic signed [DW-1:0] nl, nh;
	logic signed [DW:0]   lin_lo, lin_hi;
	always_comb begin
		nl = (cmd_s1 == CMD_DIV) ? rl_s1 : bl_s1;
		nh = (cmd_s1 == CMD_DIV) ? rh_s1 : bh_s1;
		case (cmd_s1)
			CMD_SUB: begin
				lin_lo = 33'(al_s1) - 33'(bh_s1);
				lin_hi = 33'(ah_s1) - 33'(bl_s1);
			end
			CMD_NEG: begin
				lin_lo = -33'(ah_s1);
				lin_hi = -33'(al_s1);
			end
			default: begin
				lin_lo = 33'(al_s1) + 33'(bl_s1);
				lin_hi = 33'(ah_s1) + 33'(bh_s1);
			end
		endcase
	end

	logic                 vld_s2;
	logic [2:0]           cmd_s2;
	logic signed [63:0]   p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [DW:0]   lo_s2, hi_s2;
	logic signed [DW-1:0] rl_s2, rh_s2;
	logic                 rov_s2, rdz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
			p0_s2  <= 64'(al_s1) * 64'(nl);
			p1_s2  <= 64'(ah_s1) * 64'(nh);
			p2_s2  <= 64'(al_s1) * 64'(nh);
			p3_s2  <= 64'(ah_s1) * 64'(nl);
			lo_s2  <= lin_lo;
			hi_s2  <= lin_hi;
			rl_s2  <= rl_s1;
			rh_s2  <= rh_s1;
			rov_s2 <= rov_s1;
			rdz_s2 <= rdz_s1;
		end
	end

	// min/max of floored products, saturate, select
	logic signed [63:0] q0, q1, q2, q3, mn01, mx01, mn23, mx23, mn, mx;
	sat_t smn, smx, slo, shi;
	logic signed [DW-1:0] o_lo, o_hi;
	logic                 o_ov, o_dz;

	always_comb begin
		q0 = p0_s2 >>> FRAC_BITS;
		q1 = p1_s2 >>> FRAC_BITS;
		q2 = p2_s2 >>> FRAC_BITS;
		q3 = p3_s2 >>> FRAC_BITS;
		mn01 = (q1 < q0) ? q1 : q0;
		mx01 = (q1 > q0) ? q1 : q0;
		mn23 = (q3 < q2) ? q3 : q2;
		mx23 = (q3 > q2) ? q3 : q2;
		mn = (mn23 < mn01) ? mn23 : mn01;
		mx = (mx23 > mx01) ? mx23 : mx01;
		smn = sat64(mn);
		smx = sat64(mx);
		slo = sat64(64'(lo_s2));
		shi = sat64(64'(hi_s2));
		o_lo = '0;
		o_hi = '0;
		o_ov = 1'b0;
		o_dz = 1'b0;
		case (cmd_s2)
			CMD_ADD, CMD_SUB, CMD_NEG: begin
				o_lo = slo.val;
				o_hi = shi.val;
				o_ov = slo.ov | shi.ov;
			end
			CMD_MUL: begin
				o_lo = smn.val;
				o_hi = smx.val;
				o_ov = smn.ov | smx.ov;
			end
			CMD_RECIP: begin
				o_lo = rl_s2;
				o_hi = rh_s2;
				o_ov = rov_s2;
				o_dz = rdz_s2;
			end
			CMD_DIV: begin
				o_lo = smn.val;
				o_hi = smx.val;
				o_ov = rov_s2 | smn.ov | smx.ov;
				o_dz = rdz_s2;
			end
			default: ;
		endcase
	end

	logic [2:0] cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_q    <= cmd_s2;
			res_low  <= o_lo;
			res_high <= o_hi;
			overflow <= o_ov;
			div_zero <= o_dz;
		end
	end

	`IAU_ASSERT_NOW(a_dz_implies_ov, out_valid && div_zero, overflow)
	`IAU_ASSERT_NOW(a_dz_only_recip, out_valid && div_zero, cmd_q == CMD_RECIP || cmd_q == CMD_DIV)
	`IAU_ASSERT_NOW(a_ordered, out_valid && (cmd_q == CMD_MUL || cmd_q == CMD_RECIP || cmd_q == CMD_DIV), res_low <= res_high)
	`IAU_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(cmd_q))

endmodule
